// File: sv/sad_pkg.sv
package sad_pkg;

   localparam int DEF_MAX_SOURCE  = 32;
   localparam int DEF_MAX_TARGET  = 255;
   localparam int DEF_SYMBOL_BITS = 21;

   localparam int SYMBOL_FIELD_W = 21;
   localparam int CELL_W         = 8;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_TARGET = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD      = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [1:0]                kind;
      logic [SYMBOL_FIELD_W-1:0] symbol;
      logic                      bad_symbol;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] distance;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic row_first;
      logic row_step;
      logic row_commit;
      logic fin_load;
   } cmd_type;

   typedef struct packed {
      logic row_needed;
      logic is_finish;
      logic len_zero;
      logic step_last;
      logic rsp_free;
   } sts_type;

   function automatic logic [CELL_W-1:0] sat_cell(input logic [31:0] v);
      logic [CELL_W-1:0] r;
      r = (v > 32'd255) ? 8'd255 : v[CELL_W-1:0];
      return r;
   endfunction

endpackage

// File: sv/string_alignment_distance.sv
// Clear, source append and rejected target requests complete in the idle state.
// An accepted target symbol passes the row start state, then one matrix cell per cycle
// through the row memories, one for each source symbol.
// A finish reads, then loads a registered result; it waits while a result is pending.
// Reset is synchronous: source and target are empty, no result pending.
module string_alignment_distance
   import sad_pkg::*;
#(
   parameter int MAX_SOURCE  = DEF_MAX_SOURCE,
   parameter int MAX_TARGET  = DEF_MAX_TARGET,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   sad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sad_dp #(
      .MAX_SOURCE  (MAX_SOURCE),
      .MAX_TARGET  (MAX_TARGET),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/sad_ram.sv
module sad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 33
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sad_ctrl.sv
module sad_ctrl
   import sad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ROW_START = 3'd1;
   localparam logic [2:0] S_ROW_RUN   = 3'd2;
   localparam logic [2:0] S_FIN_READ  = 3'd3;
   localparam logic [2:0] S_FIN_OUT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (sts.row_needed) begin
                  state_in = S_ROW_START;
               end else if (sts.is_finish) begin
                  state_in = S_FIN_READ;
               end
            end
         end
         S_ROW_START: begin
            cmd.row_first = 1'b1;
            if (sts.len_zero) begin
               cmd.row_commit = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_ROW_RUN;
            end
         end
         S_ROW_RUN: begin
            cmd.row_step = 1'b1;
            if (sts.step_last) begin
               cmd.row_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_FIN_READ: begin
            state_in = S_FIN_OUT;
         end
         S_FIN_OUT: begin
            if (sts.rsp_free) begin
               cmd.fin_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/sad_dp.sv
module sad_dp
   import sad_pkg::*;
#(
   parameter int MAX_SOURCE  = DEF_MAX_SOURCE,
   parameter int MAX_TARGET  = DEF_MAX_TARGET,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LEN_W  = $clog2(MAX_SOURCE + 1);
   localparam int ROW_D  = MAX_SOURCE + 1;
   localparam int SRC_AW = (MAX_SOURCE > 1) ? $clog2(MAX_SOURCE) : 1;
   localparam int TC_W   = $clog2(MAX_TARGET + 1);
   localparam int SYM_W  = (SYMBOL_BITS < SYMBOL_FIELD_W) ? SYMBOL_BITS : SYMBOL_FIELD_W;
   localparam int EXT_W  = CELL_W + 1;

   logic [LEN_W-1:0]  src_len_ff, src_len_in;
   logic              src_bad_ff, src_bad_in;
   logic              src_long_ff, src_long_in;
   logic [TC_W-1:0]   tc_ff, tc_in;
   logic              tgt_bad_ff, tgt_bad_in;
   logic              tgt_long_ff, tgt_long_in;
   logic [SYM_W-1:0]  prev_sym_ff, prev_sym_in;
   logic [SYM_W-1:0]  cur_sym_ff, cur_sym_in;
   logic [SYM_W-1:0]  src_prev_ff, src_prev_in;
   logic [LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0]  cur_idx_ff, cur_idx_in;
   logic [CELL_W-1:0] last_prev_ff, last_prev_in;
   logic [CELL_W-1:0] fresh_prev_ff, fresh_prev_in;
   logic [1:0]        new_sel_ff, new_sel_in;
   logic [1:0]        last_sel_ff, last_sel_in;
   logic [1:0]        before_sel_ff, before_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [SYM_W-1:0]  req_sym;
   logic              src_we;
   logic [SRC_AW-1:0] src_rd_addr;
   logic [SYM_W-1:0]  src_rd;
   logic [LEN_W-1:0]  last_addr;
   logic [LEN_W-1:0]  before_addr;
   logic [CELL_W-1:0] row_rd [3];
   logic [CELL_W-1:0] last_rd;
   logic [CELL_W-1:0] before_rd;
   logic [CELL_W-1:0] last_val;
   logic [CELL_W-1:0] before_val;
   logic [CELL_W-1:0] fresh0;
   logic [CELL_W-1:0] fresh;
   logic [EXT_W-1:0]  v_ins;
   logic [EXT_W-1:0]  v_del;
   logic [EXT_W-1:0]  v_sub;
   logic [EXT_W-1:0]  v_swp;
   logic [EXT_W-1:0]  v_min;
   logic [EXT_W-1:0]  v_fin;
   logic              swap_ok;
   logic              row_we;
   logic [LEN_W-1:0]  row_wr_addr;
   logic [CELL_W-1:0] row_wr_data;
   logic [LEN_W-1:0]  rd_idx_adv;
   logic              tc_zero;
   logic              tc_one;

   assign req_sym = req_data.symbol[SYM_W-1:0];
   assign tc_zero = (tc_ff == '0);
   assign tc_one  = (tc_ff == TC_W'(1));

   assign src_we      = cmd.take && (req_data.kind == KIND_APPEND) && !req_data.bad_symbol
                        && (32'(src_len_ff) < MAX_SOURCE);
   assign src_rd_addr = (rd_idx_ff != '0) ? SRC_AW'(rd_idx_ff - LEN_W'(1)) : '0;
   assign last_addr   = rd_idx_ff;
   assign before_addr = (rd_idx_ff > LEN_W'(1)) ? (rd_idx_ff - LEN_W'(2)) : '0;

   sad_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_SOURCE)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (SRC_AW'(src_len_ff)),
      .wr_data (req_sym),
      .rd_addr (src_rd_addr),
      .rd_data (src_rd)
   );

   for (genvar b = 0; b < 3; b++) begin : g_row
      sad_ram #(
         .WIDTH (CELL_W),
         .DEPTH (ROW_D)
      ) u_row_ram (
         .clock   (clock),
         .wr_en   (row_we && (new_sel_ff == 2'(b))),
         .wr_addr (row_wr_addr),
         .wr_data (row_wr_data),
         .rd_addr ((last_sel_ff == 2'(b)) ? last_addr : before_addr),
         .rd_data (row_rd[b])
      );
   end

   always_comb begin
      case (last_sel_ff)
         2'd0:    last_rd = row_rd[0];
         2'd1:    last_rd = row_rd[1];
         default: last_rd = row_rd[2];
      endcase
      case (before_sel_ff)
         2'd0:    before_rd = row_rd[0];
         2'd1:    before_rd = row_rd[1];
         default: before_rd = row_rd[2];
      endcase
   end

   assign last_val   = tc_zero ? sat_cell(32'(cur_idx_ff)) : last_rd;
   assign before_val = tc_one ? sat_cell(32'(cur_idx_ff) - 32'd2) : before_rd;
   assign fresh0     = sat_cell(32'(tc_ff) + 32'd1);

   always_comb begin
      v_ins   = {1'b0, last_val} + EXT_W'(1);
      v_del   = {1'b0, fresh_prev_ff} + EXT_W'(1);
      v_sub   = {1'b0, last_prev_ff} + EXT_W'(src_rd != cur_sym_ff);
      v_swp   = {1'b0, before_val} + EXT_W'(1);
      v_min   = (v_ins < v_del) ? v_ins : v_del;
      v_min   = (v_sub < v_min) ? v_sub : v_min;
      swap_ok = (cur_idx_ff > LEN_W'(1)) && !tc_zero && (src_rd == prev_sym_ff)
                && (src_prev_ff == cur_sym_ff);
      v_fin   = (swap_ok && (v_swp < v_min)) ? v_swp : v_min;
      fresh   = (v_fin > EXT_W'(255)) ? 8'd255 : v_fin[CELL_W-1:0];
   end

   assign row_we      = cmd.row_first || cmd.row_step;
   assign row_wr_addr = cmd.row_step ? cur_idx_ff : '0;
   assign row_wr_data = cmd.row_step ? fresh : fresh0;
   assign rd_idx_adv  = (rd_idx_ff < src_len_ff) ? (rd_idx_ff + LEN_W'(1)) : rd_idx_ff;

   assign sts.row_needed = (req_data.kind == KIND_TARGET) && !req_data.bad_symbol
                           && (tc_ff < TC_W'(MAX_TARGET));
   assign sts.is_finish  = (req_data.kind == KIND_FINISH);
   assign sts.len_zero   = (src_len_ff == '0);
   assign sts.step_last  = (cur_idx_ff == src_len_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      src_len_in    = src_len_ff;
      src_bad_in    = src_bad_ff;
      src_long_in   = src_long_ff;
      tc_in         = tc_ff;
      tgt_bad_in    = tgt_bad_ff;
      tgt_long_in   = tgt_long_ff;
      prev_sym_in   = prev_sym_ff;
      cur_sym_in    = cur_sym_ff;
      src_prev_in   = src_prev_ff;
      rd_idx_in     = rd_idx_ff;
      cur_idx_in    = cur_idx_ff;
      last_prev_in  = last_prev_ff;
      fresh_prev_in = fresh_prev_ff;
      new_sel_in    = new_sel_ff;
      last_sel_in   = last_sel_ff;
      before_sel_in = before_sel_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.take) begin
         case (req_data.kind)
            KIND_CLEAR: begin
               src_len_in  = '0;
               src_bad_in  = 1'b0;
               src_long_in = 1'b0;
               tc_in       = '0;
               tgt_bad_in  = 1'b0;
               tgt_long_in = 1'b0;
               prev_sym_in = '0;
            end
            KIND_APPEND: begin
               tc_in       = '0;
               tgt_bad_in  = 1'b0;
               tgt_long_in = 1'b0;
               prev_sym_in = '0;
               if (req_data.bad_symbol) begin
                  src_bad_in = 1'b1;
               end else if (32'(src_len_ff) >= MAX_SOURCE) begin
                  src_long_in = 1'b1;
               end else begin
                  src_len_in = src_len_ff + LEN_W'(1);
               end
            end
            KIND_TARGET: begin
               if (req_data.bad_symbol) begin
                  tgt_bad_in = 1'b1;
               end else if (tc_ff >= TC_W'(MAX_TARGET)) begin
                  tgt_long_in = 1'b1;
               end else begin
                  cur_sym_in = req_sym;
                  rd_idx_in  = LEN_W'(1);
               end
            end
            default: begin
               rd_idx_in = src_len_ff;
            end
         endcase
      end

      if (cmd.row_first) begin
         fresh_prev_in = fresh0;
         last_prev_in  = sat_cell(32'(tc_ff));
         cur_idx_in    = LEN_W'(1);
         rd_idx_in     = rd_idx_adv;
      end

      if (cmd.row_step) begin
         fresh_prev_in = fresh;
         last_prev_in  = last_val;
         src_prev_in   = src_rd;
         rd_idx_in     = rd_idx_adv;
         if (cur_idx_ff < src_len_ff) begin
            cur_idx_in = cur_idx_ff + LEN_W'(1);
         end
      end

      if (cmd.row_commit) begin
         tc_in         = tc_ff + TC_W'(1);
         prev_sym_in   = cur_sym_ff;
         last_sel_in   = new_sel_ff;
         before_sel_in = last_sel_ff;
         new_sel_in    = before_sel_ff;
      end

      if (cmd.fin_load) begin
         rsp_valid_in = 1'b1;
         if (src_bad_ff || tgt_bad_ff) begin
            rsp_data_in.status   = STATUS_BAD;
            rsp_data_in.distance = '0;
         end else if (src_long_ff || tgt_long_ff) begin
            rsp_data_in.status   = STATUS_TOO_LONG;
            rsp_data_in.distance = '0;
         end else begin
            rsp_data_in.status   = STATUS_OK;
            rsp_data_in.distance = tc_zero ? sat_cell(32'(src_len_ff)) : last_rd;
         end
         tc_in       = '0;
         tgt_bad_in  = 1'b0;
         tgt_long_in = 1'b0;
         prev_sym_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff    <= '0;
         src_bad_ff    <= 1'b0;
         src_long_ff   <= 1'b0;
         tc_ff         <= '0;
         tgt_bad_ff    <= 1'b0;
         tgt_long_ff   <= 1'b0;
         prev_sym_ff   <= '0;
         new_sel_ff    <= 2'd0;
         last_sel_ff   <= 2'd1;
         before_sel_ff <= 2'd2;
         rsp_valid_ff  <= 1'b0;
      end else begin
         src_len_ff    <= src_len_in;
         src_bad_ff    <= src_bad_in;
         src_long_ff   <= src_long_in;
         tc_ff         <= tc_in;
         tgt_bad_ff    <= tgt_bad_in;
         tgt_long_ff   <= tgt_long_in;
         prev_sym_ff   <= prev_sym_in;
         new_sel_ff    <= new_sel_in;
         last_sel_ff   <= last_sel_in;
         before_sel_ff <= before_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_sym_ff    <= cur_sym_in;
      src_prev_ff   <= src_prev_in;
      rd_idx_ff     <= rd_idx_in;
      cur_idx_ff    <= cur_idx_in;
      last_prev_ff  <= last_prev_in;
      fresh_prev_ff <= fresh_prev_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
